### sv/tslc_pkg.sv
// ----------------------------------------------------------------------------
// tslc_pkg
// Shared types and constants for the strided tensor layout checker.
// ----------------------------------------------------------------------------
package tslc_pkg;

  // field widths
  localparam int ELEM_W     = 4;
  localparam int BUF_W      = 63;
  localparam int SIZE_W     = 63;
  localparam int STRIDE_W   = 64;
  localparam int VERDICT_W  = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 63;
  localparam int PROD_W     = 2 * SIZE_W;

  // verdict codes, also used as the sticky error code (too-many overrides others)
  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_OK         = 3'd0,
    VERDICT_NEG_STRIDE = 3'd1,
    VERDICT_OFFSET_OVF = 3'd2,
    VERDICT_OVERRUN    = 3'd3,
    VERDICT_TOO_MANY   = 3'd4
  } verdict_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ELEM_BYTES   = 1'b0,
    CFG_BUFFER_BYTES = 1'b1
  } cfg_reg_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,   // waiting for a dimension word
    ST_DIM,    // per-dimension sign check, launch offset multiply
    ST_DMUL,   // offset multiply in flight
    ST_FIN,    // verdict and walk setup
    ST_CRD,    // column-major walk: read entry
    ST_CCMP,   // column-major walk: compare, launch multiply
    ST_CMUL,   // column-major walk: multiply in flight
    ST_RINIT,  // row-major walk setup
    ST_RRD,    // row-major walk: read entry
    ST_RCMP,   // row-major walk: compare, launch multiply
    ST_RMUL,   // row-major walk: multiply in flight
    ST_EMIT    // load the output register
  } state_t;

  // multiplier operand source
  typedef enum logic {
    MUL_SEL_DIM,
    MUL_SEL_WALK
  } mul_sel_t;

  // controller to datapath
  typedef struct packed {
    logic     cap;
    logic     dim_chk;
    logic     dim_acc;
    logic     mul_go;
    mul_sel_t mul_sel;
    logic     fin;
    logic     rd;
    logic     col_cmp;
    logic     col_step;
    logic     row_init;
    logic     row_cmp;
    logic     row_step;
    logic     emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_mul;
    logic last;
    logic too_many;
    logic mul_done;
    logic idx_last;
    logic idx_zero;
    logic size_zero;
    logic out_busy;
  } dp_sts_t;

endpackage

### sv/tslc_ram.sv
// ----------------------------------------------------------------------------
// tslc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tslc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [WIDTH-1:0]          wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [WIDTH-1:0]          rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/tslc_mul.sv
// ----------------------------------------------------------------------------
// tslc_mul
// 63 x 63 bit unsigned multiplier built from four 32 x 32 partial products,
// one per cycle, with overflow flag for results above 2^63 - 1.
// ----------------------------------------------------------------------------
module tslc_mul
  import tslc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SIZE_W-1:0] a,
  input  logic [SIZE_W-1:0] b,
  output logic [SIZE_W-1:0] prod,
  output logic              ovf,
  output logic              done
);
  localparam int HALF_W = 32;

  logic [SIZE_W-1:0]   a_r, b_r;
  logic                busy_r, pv_r, done_r;
  logic [2:0]          step_r;
  logic [1:0]          sh_r;
  logic [2*HALF_W-1:0] pp_r;
  logic [PROD_W-1:0]   acc_r;

  logic [HALF_W-1:0]   a_part, b_part;
  logic [PROD_W-1:0]   pp_shift;

  // operand halves: step bit 1 picks a high, step bit 0 picks b high
  always_comb begin
    a_part = step_r[1] ? {1'b0, a_r[SIZE_W-1:HALF_W]} : a_r[HALF_W-1:0];
    b_part = step_r[0] ? {1'b0, b_r[SIZE_W-1:HALF_W]} : b_r[HALF_W-1:0];
  end

  // align the previous partial product
  always_comb begin
    case (sh_r)
      2'd0:    pp_shift = {{(PROD_W-2*HALF_W){1'b0}}, pp_r};
      2'd1:    pp_shift = {{(PROD_W-3*HALF_W){1'b0}}, pp_r, {HALF_W{1'b0}}};
      default: pp_shift = {pp_r[PROD_W-2*HALF_W-1:0], {(2*HALF_W){1'b0}}};
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pv_r   <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      pv_r   <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 3'd1;
      if (step_r[2]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
        pv_r   <= 1'b0;
      end else begin
        pv_r   <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // partial products and accumulation
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      if (pv_r) begin
        acc_r <= acc_r + pp_shift;
      end
      if (!step_r[2]) begin
        pp_r <= a_part * b_part;
        sh_r <= 2'({1'b0, step_r[1]} + {1'b0, step_r[0]});
      end
    end
  end

  assign prod = acc_r[SIZE_W-1:0];
  assign ovf  = |acc_r[PROD_W-1:SIZE_W];
  assign done = done_r;

endmodule

### sv/tslc_dp.sv
// ----------------------------------------------------------------------------
// tslc_dp
// Datapath: config registers, dimension stores, offset accumulator, layout
// walk registers, shared multiplier and the output register.
// ----------------------------------------------------------------------------
module tslc_dp
  import tslc_pkg::*;
#(
  parameter int MAX_DIMS = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata,
  input  logic [SIZE_W-1:0]          in_dim_size,
  input  logic signed [STRIDE_W-1:0] in_dim_stride,
  input  logic                       in_last_dim,
  input  dp_cmd_t                    cmd,
  output dp_sts_t                    sts,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic [VERDICT_W-1:0]       out_verdict,
  output logic [SIZE_W-1:0]          out_max_offset,
  output logic                       out_row_major,
  output logic                       out_col_major,
  output logic                       out_contiguous
);
  localparam int AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CW = $clog2(MAX_DIMS + 1);

  // config
  logic [ELEM_W-1:0]   elem_r;
  logic [BUF_W-1:0]    buf_r;
  // captured word
  logic [SIZE_W-1:0]   sz_r;
  logic [STRIDE_W-1:0] st_r;
  logic                last_r, stored_r;
  // descriptor state
  logic [CW-1:0]       cnt_r;
  logic [SIZE_W-1:0]   acc_r;
  verdict_t            err_r;
  logic                zero_r;
  // walk state
  logic [AW-1:0]       idx_r;
  logic [SIZE_W-1:0]   exp_r;
  logic                ovf_r, zf_r, match_r, alleq_r, row_r, col_r;
  verdict_t            verdict_r;
  logic [SIZE_W-1:0]   maxoff_r;
  // output register
  logic                out_valid_r;
  logic [VERDICT_W-1:0] out_verdict_r;
  logic [SIZE_W-1:0]   out_max_offset_r;
  logic                out_row_r, out_col_r, out_contig_r;

  logic                has_room;
  logic                wr_en;
  logic [SIZE_W-1:0]   rd_size;
  logic [STRIDE_W-1:0] rd_stride;
  logic [SIZE_W-1:0]   mul_a, mul_b, mul_prod;
  logic                mul_ovf, mul_done;
  logic [SIZE_W-1:0]   elem_ext;
  logic [STRIDE_W-1:0] elem_st;
  logic [STRIDE_W-1:0] sum;
  logic [STRIDE_W-1:0] end_off;
  logic                overrun;
  logic                size_zero;
  logic                match_now, alleq_now;

  // dimension stores
  assign has_room = cnt_r < CW'(MAX_DIMS);
  assign wr_en    = cmd.cap && has_room;

  tslc_ram #(.WIDTH(SIZE_W), .DEPTH(MAX_DIMS)) u_size_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(cnt_r)),
    .wr_data (in_dim_size),
    .rd_en   (cmd.rd),
    .rd_addr (idx_r),
    .rd_data (rd_size)
  );

  tslc_ram #(.WIDTH(STRIDE_W), .DEPTH(MAX_DIMS)) u_stride_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(cnt_r)),
    .wr_data (in_dim_stride),
    .rd_en   (cmd.rd),
    .rd_addr (idx_r),
    .rd_data (rd_stride)
  );

  // shared multiplier
  assign mul_a = (cmd.mul_sel == MUL_SEL_DIM) ? (sz_r - SIZE_W'(1)) : exp_r;
  assign mul_b = (cmd.mul_sel == MUL_SEL_DIM) ? st_r[SIZE_W-1:0] : rd_size;

  tslc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_go),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_prod),
    .ovf   (mul_ovf),
    .done  (mul_done)
  );

  // arithmetic and compares
  assign elem_ext  = {{(SIZE_W-ELEM_W){1'b0}}, elem_r};
  assign elem_st   = {{(STRIDE_W-ELEM_W){1'b0}}, elem_r};
  assign sum       = {1'b0, acc_r} + {1'b0, mul_prod};
  // acc + elem > buf  is the same as  buf < elem or acc > buf - elem
  assign end_off   = {1'b0, acc_r} + elem_st;
  assign overrun   = end_off > {1'b0, buf_r};
  assign size_zero = (rd_size == '0);
  assign match_now = match_r && (rd_stride == {1'b0, exp_r});
  assign alleq_now = alleq_r && (rd_stride == elem_st);

  // status
  always_comb begin
    sts.need_mul  = (err_r == VERDICT_OK) && stored_r && (sz_r != '0) &&
                    !st_r[STRIDE_W-1];
    sts.last      = last_r;
    sts.too_many  = (err_r == VERDICT_TOO_MANY);
    sts.mul_done  = mul_done;
    sts.idx_last  = (CW'(idx_r) == (cnt_r - CW'(1)));
    sts.idx_zero  = (idx_r == '0);
    sts.size_zero = size_zero;
    sts.out_busy  = out_valid_r && out_stall;
  end

  // config, descriptor state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_r      <= ELEM_W'(1);
      buf_r       <= '0;
      cnt_r       <= '0;
      acc_r       <= '0;
      err_r       <= VERDICT_OK;
      zero_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_ELEM_BYTES:   elem_r <= cfg_wdata[ELEM_W-1:0];
          CFG_BUFFER_BYTES: buf_r  <= cfg_wdata[BUF_W-1:0];
          default: ;
        endcase
      end
      // new dimension word
      if (cmd.cap) begin
        if (has_room) begin
          cnt_r <= cnt_r + CW'(1);
          if (in_dim_size == '0) begin
            zero_r <= 1'b1;
          end
        end else begin
          err_r <= VERDICT_TOO_MANY;
        end
      end
      // negative stride on a non-empty dimension
      if (cmd.dim_chk && (err_r == VERDICT_OK) && stored_r && (sz_r != '0) &&
          st_r[STRIDE_W-1]) begin
        err_r <= VERDICT_NEG_STRIDE;
      end
      // add (size - 1) * stride into the largest offset
      if (cmd.dim_acc) begin
        if (mul_ovf || sum[STRIDE_W-1]) begin
          err_r <= VERDICT_OFFSET_OVF;
        end else begin
          acc_r <= sum[SIZE_W-1:0];
        end
      end
      // descriptor closed
      if (cmd.emit) begin
        cnt_r  <= '0;
        acc_r  <= '0;
        err_r  <= VERDICT_OK;
        zero_r <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // captured word, verdict, layout walks, output payload
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      sz_r     <= in_dim_size;
      st_r     <= in_dim_stride;
      last_r   <= in_last_dim;
      stored_r <= has_room;
    end

    // verdict and column-major walk setup
    if (cmd.fin) begin
      if (err_r == VERDICT_TOO_MANY) begin
        verdict_r <= VERDICT_TOO_MANY;
        maxoff_r  <= '0;
        row_r     <= 1'b0;
        col_r     <= 1'b0;
      end else if ((buf_r == '0) && zero_r) begin
        verdict_r <= VERDICT_OK;
        maxoff_r  <= '0;
      end else if (err_r != VERDICT_OK) begin
        verdict_r <= err_r;
        maxoff_r  <= '0;
      end else if (overrun) begin
        verdict_r <= VERDICT_OVERRUN;
        maxoff_r  <= '0;
      end else begin
        verdict_r <= VERDICT_OK;
        maxoff_r  <= acc_r;
      end
      exp_r   <= elem_ext;
      ovf_r   <= 1'b0;
      zf_r    <= (elem_r == '0);
      match_r <= 1'b1;
      alleq_r <= 1'b1;
      idx_r   <= '0;
    end

    // column-major: expected stride is elem times sizes of outer dims
    if (cmd.col_cmp) begin
      match_r <= match_now;
      alleq_r <= alleq_now;
      if (sts.idx_last) begin
        if (size_zero) begin
          col_r <= alleq_now;
        end else if (ovf_r) begin
          col_r <= 1'b0;
        end else if (zf_r) begin
          col_r <= alleq_now;
        end else begin
          col_r <= match_now;
        end
      end else if (size_zero) begin
        zf_r <= 1'b1;
      end
    end
    if (cmd.col_step) begin
      exp_r <= mul_prod;
      ovf_r <= ovf_r | mul_ovf;
      idx_r <= idx_r + AW'(1);
    end

    // row-major walk runs innermost to outermost
    if (cmd.row_init) begin
      exp_r   <= elem_ext;
      ovf_r   <= 1'b0;
      zf_r    <= (elem_r == '0);
      match_r <= 1'b1;
      idx_r   <= AW'(cnt_r - CW'(1));
    end
    if (cmd.row_cmp) begin
      match_r <= match_now;
      if (sts.idx_zero) begin
        if (size_zero) begin
          row_r <= alleq_r;
        end else if (ovf_r) begin
          row_r <= 1'b0;
        end else if (zf_r) begin
          row_r <= alleq_r;
        end else begin
          row_r <= match_now;
        end
      end else if (size_zero) begin
        // a zero size restarts the product; only the segment outside the
        // outermost zero can overflow
        exp_r <= elem_ext;
        ovf_r <= 1'b0;
        zf_r  <= 1'b1;
        idx_r <= idx_r - AW'(1);
      end
    end
    if (cmd.row_step) begin
      exp_r <= mul_prod;
      ovf_r <= ovf_r | mul_ovf;
      idx_r <= idx_r - AW'(1);
    end

    // output register
    if (cmd.emit) begin
      out_verdict_r    <= verdict_r;
      out_max_offset_r <= maxoff_r;
      out_row_r        <= row_r;
      out_col_r        <= col_r;
      out_contig_r     <= row_r | col_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_verdict    = out_verdict_r;
  assign out_max_offset = out_max_offset_r;
  assign out_row_major  = out_row_r;
  assign out_col_major  = out_col_r;
  assign out_contiguous = out_contig_r;

endmodule

### sv/tslc_ctrl.sv
// ----------------------------------------------------------------------------
// tslc_ctrl
// Controller: sequences word capture, offset multiply, verdict and the two
// layout walks, and hands the result to the output register.
// ----------------------------------------------------------------------------
module tslc_ctrl
  import tslc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);
  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.mul_sel = MUL_SEL_DIM;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = ST_DIM;
        end
      end
      ST_DIM: begin
        if (sts.need_mul) begin
          cmd.mul_go = 1'b1;
          state_nxt  = ST_DMUL;
        end else begin
          cmd.dim_chk = 1'b1;
          state_nxt   = sts.last ? ST_FIN : ST_IDLE;
        end
      end
      ST_DMUL: begin
        if (sts.mul_done) begin
          cmd.dim_acc = 1'b1;
          state_nxt   = sts.last ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = sts.too_many ? ST_EMIT : ST_CRD;
      end
      ST_CRD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_CCMP;
      end
      ST_CCMP: begin
        cmd.col_cmp = 1'b1;
        if (sts.idx_last) begin
          state_nxt = ST_RINIT;
        end else begin
          cmd.mul_go  = 1'b1;
          cmd.mul_sel = MUL_SEL_WALK;
          state_nxt   = ST_CMUL;
        end
      end
      ST_CMUL: begin
        if (sts.mul_done) begin
          cmd.col_step = 1'b1;
          state_nxt    = ST_CRD;
        end
      end
      ST_RINIT: begin
        cmd.row_init = 1'b1;
        state_nxt    = ST_RRD;
      end
      ST_RRD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_RCMP;
      end
      ST_RCMP: begin
        cmd.row_cmp = 1'b1;
        if (sts.idx_zero) begin
          state_nxt = ST_EMIT;
        end else if (sts.size_zero) begin
          state_nxt = ST_RRD;
        end else begin
          cmd.mul_go  = 1'b1;
          cmd.mul_sel = MUL_SEL_WALK;
          state_nxt   = ST_RMUL;
        end
      end
      ST_RMUL: begin
        if (sts.mul_done) begin
          cmd.row_step = 1'b1;
          state_nxt    = ST_RRD;
        end
      end
      ST_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

### sv/tensor_stride_layout_check_core.sv
// ----------------------------------------------------------------------------
// tensor_stride_layout_check_core
// Strided tensor descriptor checker: one dimension per word, one verdict
// with largest offset and layout flags per descriptor.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          word
//  in_       input      in_valid/in_stall  dim_size, dim_stride, last_dim
//  out_      output     out_valid/out_stall verdict, max_offset, layout flags
//  cfg_      input      cfg_we             cfg_index, cfg_wdata
//
//  A dimension word with a non-empty size and a non-negative stride, while no
//  error is recorded, also waits for its offset product from the shared
//  multiplier. A closing word adds the verdict and two walks over the n stored
//  dimensions, each entry a RAM read, a compare and, but for the last entry of
//  a walk, a multiply; an empty dimension skips a row-major multiply, and with
//  too many dims both walks are skipped. The closing item waits only
//  while the output register still holds an untaken word; stalls on the
//  output side are absorbed there. Reset is synchronous and leaves no
//  clearing pass.
// ----------------------------------------------------------------------------
module tensor_stride_layout_check_core
  import tslc_pkg::*;
#(
  parameter int MAX_DIMS = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [SIZE_W-1:0]          in_dim_size,
  input  logic signed [STRIDE_W-1:0] in_dim_stride,
  input  logic                       in_last_dim,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [VERDICT_W-1:0]       out_verdict,
  output logic [SIZE_W-1:0]          out_max_offset,
  output logic                       out_row_major,
  output logic                       out_col_major,
  output logic                       out_contiguous
);
  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer
  tslc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  tslc_dp #(.MAX_DIMS(MAX_DIMS)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_dim_size    (in_dim_size),
    .in_dim_stride  (in_dim_stride),
    .in_last_dim    (in_last_dim),
    .cmd            (cmd),
    .sts            (sts),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_verdict    (out_verdict),
    .out_max_offset (out_max_offset),
    .out_row_major  (out_row_major),
    .out_col_major  (out_col_major),
    .out_contiguous (out_contiguous)
  );

endmodule

### sv/tslc_chk.sv
// ----------------------------------------------------------------------------
// tslc_chk
// Port-level checks for the tensor layout checker, bound to the top level.
// ----------------------------------------------------------------------------
module tslc_chk
  import tslc_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [VERDICT_W-1:0]       out_verdict,
  input logic [SIZE_W-1:0]          out_max_offset,
  input logic                       out_row_major,
  input logic                       out_col_major,
  input logic                       out_contiguous
);

  // a stalled result word holds its verdict and offset
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_verdict) &&
      $stable(out_max_offset))
    else $error("result word changed while stalled");

  // too many dims clears the offset and both layout flags
  a_too_many: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_verdict == VERDICT_TOO_MANY) |->
      (out_max_offset == '0) && !out_row_major && !out_col_major)
    else $error("too-many-dims verdict with nonzero fields");

  // error verdicts carry no offset
  a_err_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_verdict != VERDICT_OK) |-> (out_max_offset == '0))
    else $error("error verdict with nonzero offset");

  // contiguous is the or of the two layout flags
  a_contig: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_contiguous == (out_row_major || out_col_major)))
    else $error("contiguous flag inconsistent");

  // after reset: no result pending, input open
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("state not cleared by reset");

endmodule

bind tensor_stride_layout_check_core tslc_chk u_tslc_chk (.*);
